/* src/triangle_clip_by_sign_top_macros.svh */
// Assertion macros for the triangle clipper.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef TRIANGLE_CLIP_BY_SIGN_TOP_MACROS_SVH
`define TRIANGLE_CLIP_BY_SIGN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle clipper check failed");
`define TCS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle clipper check failed");
`else
`define TCS_ASSERT_IMPL(name, ante, cons)
`define TCS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* src/tcs_pkg.sv */
// Types and constants shared by the triangle clipper.
// Used by tcs_scale_lane and triangle_clip_by_sign_top; depends on nothing.
package tcs_pkg;

    localparam int CW = 32;          // coordinate width
    localparam int VW = 32;          // cut value width
    localparam int DW = VW + 1;      // denominator width
    localparam int QW = CW + 1;      // partial quotient width
    localparam int LANE_LAT = CW + 2;
    localparam int NUM_LANES = 6;
    localparam int NUM_SLOTS = 5;
    localparam int IDX_W = 4;
    localparam int SEQ_LEN = 9;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [VW-1:0] val_t;
    typedef logic [CW-1:0]        mag_t;
    typedef logic [VW-2:0]        num_t;
    typedef logic [DW-1:0]        den_t;
    typedef logic [VW-1:0]        rem_t;
    typedef logic [QW-1:0]        quot_t;
    typedef logic [1:0]           corner_idx_t;
    typedef logic [2:0]           slot_t;
    typedef logic [IDX_W-1:0]     seq_idx_t;

    // Element 0 is x, 1 is y, 2 is z.
    typedef coord_t [2:0] vertex_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ONE,
        CLS_TWO,
        CLS_ALL
    } cls_t;

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t a_z;
        val_t   a_value;
        coord_t b_x;
        coord_t b_y;
        coord_t b_z;
        val_t   b_value;
        coord_t c_x;
        coord_t c_y;
        coord_t c_z;
        val_t   c_value;
    } tri_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   last_vertex;
    } vtx_t;

    typedef struct packed {
        coord_t start;
        mag_t   mag;
        logic   up;
        num_t   num;
        den_t   den;
    } lane_in_t;

    typedef struct packed {
        cls_t    cls;
        vertex_t e0;
        vertex_t e1;
        vertex_t e2;
    } side_t;

    localparam seq_idx_t LAST_THREE = seq_idx_t'(2);
    localparam seq_idx_t LAST_NINE  = seq_idx_t'(SEQ_LEN - 1);

    // Slot order for the two-inside case. Slots hold: first inside corner,
    // first crossing, midpoint, second crossing, second inside corner.
    localparam slot_t SEQ_TWO [SEQ_LEN] = '{
        3'd0, 3'd1, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2, 3'd3, 3'd4
    };

endpackage

/* src/tcs_scale_lane.sv */
// One crossing coordinate: start +/- round(mag * num / den), one quotient bit per stage.
// Depends on tcs_pkg.
module tcs_scale_lane (
    input  logic              clk,
    input  logic              en,
    input  tcs_pkg::lane_in_t lane_in,
    output tcs_pkg::coord_t   result
);
    import tcs_pkg::*;

    rem_t   rem_reg   [CW];
    quot_t  quot_reg  [CW];
    mag_t   mag_reg   [CW];
    num_t   num_reg   [CW];
    den_t   den_reg   [CW];
    coord_t start_reg [CW];
    logic   up_reg    [CW];

    mag_t   rq_reg;
    coord_t rs_reg;
    logic   rup_reg;
    coord_t result_reg;

    for (genvar i = 0; i < CW; i++) begin : g_step
        rem_t   r_in;
        quot_t  q_in;
        mag_t   m_in;
        num_t   n_in;
        den_t   d_in;
        coord_t s_in;
        logic   u_in;
        logic [VW+1:0] rr;
        logic [VW+1:0] den1;
        logic [VW+1:0] den2;
        logic [VW+1:0] sub1;
        logic [VW+1:0] sub2;
        rem_t   rem_next;
        quot_t  quot_next;

        if (i == 0) begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign m_in = lane_in.mag;
            assign n_in = lane_in.num;
            assign d_in = lane_in.den;
            assign s_in = lane_in.start;
            assign u_in = lane_in.up;
        end
        else begin : g_rest
            assign r_in = rem_reg[i-1];
            assign q_in = quot_reg[i-1];
            assign m_in = mag_reg[i-1];
            assign n_in = num_reg[i-1];
            assign d_in = den_reg[i-1];
            assign s_in = start_reg[i-1];
            assign u_in = up_reg[i-1];
        end

        always_comb
        begin
            rr   = {1'b0, r_in, 1'b0}
                 + (m_in[CW-1-i] ? {3'b000, n_in} : {(VW+2){1'b0}});
            den1 = {1'b0, d_in};
            den2 = {d_in, 1'b0};
            sub1 = rr - den1;
            sub2 = rr - den2;
            if (rr >= den2)
            begin
                rem_next  = sub2[VW-1:0];
                quot_next = {q_in[QW-2:0], 1'b0} + quot_t'(2);
            end
            else if (rr >= den1)
            begin
                rem_next  = sub1[VW-1:0];
                quot_next = {q_in[QW-2:0], 1'b0} + quot_t'(1);
            end
            else
            begin
                rem_next  = rr[VW-1:0];
                quot_next = {q_in[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]   <= rem_next;
                quot_reg[i]  <= quot_next;
                mag_reg[i]   <= m_in;
                num_reg[i]   <= n_in;
                den_reg[i]   <= d_in;
                start_reg[i] <= s_in;
                up_reg[i]    <= u_in;
            end
        end
    end

    // Round to nearest, ties away from the start corner, then step from it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq_reg  <= quot_reg[CW-1][CW-1:0]
                     + (({rem_reg[CW-1], 1'b0} >= den_reg[CW-1]) ? mag_t'(1) : mag_t'(0));
            rs_reg  <= start_reg[CW-1];
            rup_reg <= up_reg[CW-1];
            result_reg <= rup_reg ? coord_t'(mag_t'(rs_reg) + rq_reg)
                                  : coord_t'(mag_t'(rs_reg) - rq_reg);
        end
    end

    assign result = result_reg;

endmodule

/* src/triangle_clip_by_sign_top.sv */
// Top level of the triangle clipper: classification, crossing lanes and vertex emitter.
// Depends on tcs_pkg, tcs_scale_lane and triangle_clip_by_sign_top_macros.svh.
//
// Use: a triangle word (three corners with x, y, z and a signed cut value) is
// offered on tri_valid/tri_word and taken at an edge where tri_stall is low.
// Each vertex leaves as one word on vtx_valid/vtx_word and is taken at an edge
// where vtx_stall is low; last_vertex marks the final vertex of a triangle.
// A triangle with no corner inside gives no word, one with one or three
// corners inside gives three words, one with two corners inside gives nine.
// A new triangle may enter every cycle while tri_stall is low; the emitter
// sends one vertex word per cycle while vtx_stall is low. The crossing
// lanes are pipelines of one quotient bit per stage, and the single output
// port sets the rate.
// When the receiver stalls, the output register holds its word and, once the
// emitter has a triangle waiting behind it, the whole pipeline freezes and
// tri_stall is raised; nothing is lost or repeated.
// Reset empties every stage and the output register; no clearing pass follows.
`include "triangle_clip_by_sign_top_macros.svh"

module triangle_clip_by_sign_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tri_valid,
    output logic          tri_stall,
    input  tcs_pkg::tri_t tri_word,
    output logic          vtx_valid,
    input  logic          vtx_stall,
    output tcs_pkg::vtx_t vtx_word
);
    import tcs_pkg::*;

    function automatic corner_idx_t next_corner(corner_idx_t k);
        unique case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic vertex_t pick_pos(corner_idx_t k, tri_t w);
        unique case (k)
            2'd1:    return {w.b_z, w.b_y, w.b_x};
            2'd2:    return {w.c_z, w.c_y, w.c_x};
            default: return {w.a_z, w.a_y, w.a_x};
        endcase
    endfunction

    function automatic val_t pick_val(corner_idx_t k, tri_t w);
        unique case (k)
            2'd1:    return w.b_value;
            2'd2:    return w.c_value;
            default: return w.a_value;
        endcase
    endfunction

    function automatic lane_in_t make_lane(coord_t s, coord_t t, val_t va, val_t vb);
        lane_in_t l;
        logic signed [CW:0] fwd;
        logic signed [CW:0] bwd;
        fwd     = {t[CW-1], t} - {s[CW-1], s};
        bwd     = {s[CW-1], s} - {t[CW-1], t};
        l.start = s;
        l.up    = !fwd[CW];
        l.mag   = fwd[CW] ? bwd[CW-1:0] : fwd[CW-1:0];
        l.num   = va[VW-2:0];
        l.den   = {va[VW-1], va} - {vb[VW-1], vb};
        return l;
    endfunction

    // Pipeline control: everything advances together unless the emitter
    // still owns a triangle and the tail of the pipeline holds the next one.
    logic advance;

    logic s0_valid_reg;
    tri_t s0_word_reg;

    logic     sb_valid_reg [LANE_LAT+1];
    side_t    sb_reg       [LANE_LAT+1];
    lane_in_t lane_reg     [NUM_LANES];
    coord_t   lane_res     [NUM_LANES];

    // Classification of the registered triangle.
    logic [2:0]  ins;
    logic [1:0]  num_in;
    corner_idx_t k_in;
    corner_idx_t k_out;
    corner_idx_t pin    [2];
    corner_idx_t pout   [2];
    vertex_t     pos_in [2];
    vertex_t     pos_out[2];
    val_t        val_in [2];
    val_t        val_out[2];
    vertex_t     mid;
    side_t       side_next;
    lane_in_t    lane_next [NUM_LANES];

    always_comb
    begin
        ins[0] = s0_word_reg.a_value > 0;
        ins[1] = s0_word_reg.b_value > 0;
        ins[2] = s0_word_reg.c_value > 0;
        num_in = 2'($countones(ins));
        k_in   = ins[0] ? 2'd0 : (ins[1] ? 2'd1 : 2'd2);
        k_out  = !ins[0] ? 2'd0 : (!ins[1] ? 2'd1 : 2'd2);

        side_next.e0 = pick_pos(2'd0, s0_word_reg);
        side_next.e1 = pick_pos(2'd1, s0_word_reg);
        side_next.e2 = pick_pos(2'd2, s0_word_reg);

        if (ins == 3'b000)
        begin
            side_next.cls = CLS_NONE;
        end
        else if (ins == 3'b111)
        begin
            side_next.cls = CLS_ALL;
        end
        else if (num_in == 2'd1)
        begin
            side_next.cls = CLS_ONE;
        end
        else
        begin
            side_next.cls = CLS_TWO;
        end

        if (side_next.cls == CLS_TWO)
        begin
            // Crossings run from each inside corner toward the outside one.
            pin[0]  = next_corner(next_corner(k_out));
            pout[0] = k_out;
            pin[1]  = next_corner(k_out);
            pout[1] = k_out;
        end
        else
        begin
            pin[0]  = k_in;
            pout[0] = next_corner(k_in);
            pin[1]  = k_in;
            pout[1] = next_corner(next_corner(k_in));
        end

        for (int j = 0; j < 2; j++)
        begin
            pos_in[j]  = pick_pos(pin[j], s0_word_reg);
            pos_out[j] = pick_pos(pout[j], s0_word_reg);
            val_in[j]  = pick_val(pin[j], s0_word_reg);
            val_out[j] = pick_val(pout[j], s0_word_reg);
        end

        // Midpoint of the two inside corners, rounded towards minus infinity.
        for (int c = 0; c < 3; c++)
        begin
            mid[c] = coord_t'(({pos_in[0][c][CW-1], pos_in[0][c]}
                             + {pos_in[1][c][CW-1], pos_in[1][c]}) >>> 1);
        end

        if (side_next.cls == CLS_ONE)
        begin
            side_next.e0 = pos_in[0];
        end
        else if (side_next.cls == CLS_TWO)
        begin
            side_next.e0 = pos_in[0];
            side_next.e1 = mid;
            side_next.e2 = pos_in[1];
        end

        for (int j = 0; j < 2; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                lane_next[j*3+c] = make_lane(pos_in[j][c], pos_out[j][c],
                                             val_in[j], val_out[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            for (int i = 0; i <= LANE_LAT; i++)
            begin
                sb_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            s0_valid_reg    <= tri_valid;
            sb_valid_reg[0] <= s0_valid_reg;
            for (int i = 1; i <= LANE_LAT; i++)
            begin
                sb_valid_reg[i] <= sb_valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_word_reg <= tri_word;
            sb_reg[0]   <= side_next;
            for (int i = 1; i <= LANE_LAT; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
            for (int l = 0; l < NUM_LANES; l++)
            begin
                lane_reg[l] <= lane_next[l];
            end
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        tcs_scale_lane u_lane (
            .clk     (clk),
            .en      (advance),
            .lane_in (lane_reg[l]),
            .result  (lane_res[l])
        );
    end

    // Vertex emitter: holds up to five distinct vertices of one triangle and
    // walks through them, one word per cycle while vtx_stall is low.
    logic     tail_valid;
    side_t    tail;
    vertex_t  cross_pos [2];
    vertex_t  w_reg [NUM_SLOTS];
    logic     busy_reg;
    logic     busy_next;
    logic     nine_reg;
    seq_idx_t idx_reg;
    seq_idx_t idx_next;
    logic     out_valid_reg;
    vtx_t     out_word_reg;
    logic     out_load;
    logic     emit;
    logic     last_now;
    logic     take;
    logic     load_new;
    slot_t    slot;

    assign tail_valid = sb_valid_reg[LANE_LAT];
    assign tail       = sb_reg[LANE_LAT];

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cross_pos[j][c] = lane_res[j*3+c];
            end
        end
    end

    assign out_load = !out_valid_reg || !vtx_stall;
    assign emit     = busy_reg && out_load;
    assign last_now = nine_reg ? (idx_reg == LAST_NINE) : (idx_reg == LAST_THREE);
    assign take     = !busy_reg || (emit && last_now);
    assign advance  = !tail_valid || take;
    assign load_new = advance && tail_valid && (tail.cls != CLS_NONE);
    assign slot     = nine_reg ? SEQ_TWO[idx_reg] : idx_reg[2:0];

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load_new)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (emit)
        begin
            busy_next = !last_now;
            idx_next  = idx_reg + seq_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_new)
        begin
            nine_reg <= (tail.cls == CLS_TWO);
            unique case (tail.cls)
                CLS_ALL:
                begin
                    w_reg[0] <= tail.e0;
                    w_reg[1] <= tail.e1;
                    w_reg[2] <= tail.e2;
                end
                CLS_TWO:
                begin
                    w_reg[0] <= tail.e0;
                    w_reg[1] <= cross_pos[0];
                    w_reg[2] <= tail.e1;
                    w_reg[3] <= cross_pos[1];
                    w_reg[4] <= tail.e2;
                end
                default:
                begin
                    w_reg[0] <= cross_pos[0];
                    w_reg[1] <= cross_pos[1];
                    w_reg[2] <= tail.e0;
                end
            endcase
        end
        if (emit)
        begin
            out_word_reg.px          <= w_reg[slot][0];
            out_word_reg.py          <= w_reg[slot][1];
            out_word_reg.pz          <= w_reg[slot][2];
            out_word_reg.last_vertex <= last_now;
        end
    end

    assign tri_stall = !advance;
    assign vtx_valid = out_valid_reg;
    assign vtx_word  = out_word_reg;

    `TCS_ASSERT_IMPL(a_idx_range, busy_reg, idx_reg <= (nine_reg ? LAST_NINE : LAST_THREE))
    `TCS_ASSERT_IMPL(a_hold_when_full, tail_valid && busy_reg && !out_load, tri_stall)
    `TCS_ASSERT_NEXT(a_restart, emit && last_now, !busy_reg || idx_reg == '0)
    `TCS_ASSERT_NEXT(a_word_from_busy, emit, vtx_valid)

endmodule
